FILE: hdl/rtc_pkg.sv
// rtc_pkg: shared types and constants of the rgb to cct (mccamy) block
// no dependencies
package rtc_pkg;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [15:0] KELVIN_MAX = 16'hFFFF;

    // rgb to xyz matrix in units of 1e-5, rows x y z, columns r g b
    localparam longint XYZ_COEF [9] = '{
        -14282, 154924, -95641,
        -32466, 157837, -73191,
        -68202,  77073,  56332
    };

    typedef struct packed {
        logic zero;
        logic sat_pos;
        logic sat_neg;
        logic neg;
    } t_flags;

endpackage

FILE: hdl/rtc_if.sv
// rtc_in_if and rtc_out_if: valid/ready channels for samples and results
// no dependencies
interface rtc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;

    modport source(output valid, red, green, blue, input ready);
    modport sink(input valid, red, green, blue, output ready);
endinterface

interface rtc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] kelvin;
    logic [1:0]  status;

    modport source(output valid, kelvin, status, input ready);
    modport sink(input valid, kelvin, status, output ready);
endinterface

FILE: hdl/rtc_div.sv
// rtc_div: pipelined restoring divider, one quotient bit per stage
// rtc_kdiv: pipelined division by a constant, one 8-bit quotient digit per stage
// no dependencies; rtc_div needs the dividend's upper part already below the divisor
module rtc_div #(
    parameter int QW = 8,
    parameter int DW = 8,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_low,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic          r_vld  [QW];
    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_lq   [QW];
    logic [DW-1:0] r_den  [QW];
    logic [SW-1:0] r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          s_vld;
        logic [DW-1:0] s_rem;
        logic [QW-1:0] s_lq;
        logic [DW-1:0] s_den;
        logic [SW-1:0] s_side;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] n_rem;

        if (k == 0) begin : g_first
            assign s_vld  = i_valid;
            assign s_rem  = i_rem;
            assign s_lq   = i_low;
            assign s_den  = i_den;
            assign s_side = i_side;
        end else begin : g_next
            assign s_vld  = r_vld[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_lq   = r_lq[k-1];
            assign s_den  = r_den[k-1];
            assign s_side = r_side[k-1];
        end

        assign trial = {s_rem, s_lq[QW-1]};
        assign ge    = trial >= {1'b0, s_den};
        assign n_rem = ge ? DW'(trial - {1'b0, s_den}) : DW'(trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_lq[k]   <= {s_lq[QW-2:0], ge};
                r_den[k]  <= s_den;
                r_side[k] <= s_side;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_lq[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

module rtc_kdiv #(
    parameter int NW  = 16,
    parameter int QW  = 16,
    parameter int DEN = 10,
    parameter int SW  = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    localparam int GW = 8;
    localparam int ND = (NW + GW - 1) / GW;
    localparam int PW = ND * GW;
    localparam int RW = $clog2(DEN);
    localparam int XW = RW + GW;
    localparam int SH = XW + RW;
    localparam int MW = XW + 2;
    // rounded-up reciprocal, exact for every remainder-and-digit word
    localparam logic [MW-1:0] RECIP = MW'(((longint'(1) <<< SH) + DEN - 1) / DEN);

    logic          r_vld  [ND];
    logic [RW-1:0] r_rem  [ND];
    logic [PW-1:0] r_num  [ND];
    logic [SW-1:0] r_side [ND];

    for (genvar k = 0; k < ND; k++) begin : g_stage
        logic             s_vld;
        logic [RW-1:0]    s_rem;
        logic [PW-1:0]    s_num;
        logic [SW-1:0]    s_side;
        logic [XW-1:0]    x;
        logic [XW+MW-1:0] prod;
        logic [GW-1:0]    qd;
        logic [RW-1:0]    n_rem;

        if (k == 0) begin : g_first
            assign s_vld  = i_valid;
            assign s_rem  = '0;
            assign s_num  = PW'(i_num);
            assign s_side = i_side;
        end else begin : g_next
            assign s_vld  = r_vld[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_num  = r_num[k-1];
            assign s_side = r_side[k-1];
        end

        assign x     = {s_rem, s_num[PW-1 -: GW]};
        assign prod  = (XW+MW)'(x) * (XW+MW)'(RECIP);
        assign qd    = prod[SH +: GW];
        assign n_rem = RW'(x - XW'(qd) * XW'(DEN));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_num[k]  <= (s_num << GW) | PW'(qd);
                r_side[k] <= s_side;
            end
        end
    end

    assign o_valid = r_vld[ND-1];
    assign o_quo   = r_num[ND-1][QW-1:0];
    assign o_side  = r_side[ND-1];

endmodule

FILE: hdl/rtc_cubic.sv
// rtc_cubic: horner evaluation of the mccamy cubic and final clamp
// depends on rtc_pkg
module rtc_cubic #(
    parameter int F = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [F+2:0]         i_q,
    input  rtc_pkg::t_flags      i_flags,
    output logic                 o_valid,
    output logic [15:0]          o_kelvin,
    output logic [1:0]           o_status
);

    localparam int TW = F + 19;
    localparam int MW = TW - 1;
    localparam int QW = F + 3;
    localparam int PW = MW + QW;

    localparam logic signed [TW-1:0] K3 = TW'(longint'(3525) <<< F);
    localparam logic signed [TW-1:0] K2 = TW'(((longint'(68233) <<< F) + 5) / 10);
    localparam logic signed [TW-1:0] K1 = TW'(((longint'(552033) <<< F) + 50) / 100);

    logic                   r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic signed [TW-1:0]   r_t1, r_t2, r_t3;
    logic [QW-1:0]          r_q1, r_q2, r_q3, r_q4;
    rtc_pkg::t_flags        r_f1, r_f2, r_f3, r_f4, r_f5;
    logic [PW-1:0]          r_p2, r_p4;
    logic                   r_s2, r_s4;
    logic [15:0]            r_kelvin;
    logic [1:0]             r_status;

    logic [MW-1:0]          m449;
    logic signed [TW-1:0]   n_t1, n_t2, n_t3;
    logic [MW-1:0]          t1_mag, t2_mag, sh2, sh4, t3_mag, t3_int;
    logic [15:0]            n_kelvin;
    logic [1:0]             n_status;

    assign m449   = MW'(i_q) * MW'(449);
    assign n_t1   = i_flags.neg ? K3 - $signed({1'b0, m449}) : K3 + $signed({1'b0, m449});
    assign t1_mag = r_t1[TW-1] ? MW'(-r_t1) : MW'(r_t1);
    assign sh2    = MW'(r_p2 >> F);
    assign n_t2   = (r_s2 ? -$signed({1'b0, sh2}) : $signed({1'b0, sh2})) + K2;
    assign t2_mag = r_t2[TW-1] ? MW'(-r_t2) : MW'(r_t2);
    assign sh4    = MW'(r_p4 >> F);
    assign n_t3   = (r_s4 ? -$signed({1'b0, sh4}) : $signed({1'b0, sh4})) + K1;
    assign t3_mag = MW'(-r_t3);
    assign t3_int = MW'(r_t3) >> F;

    always_comb begin
        n_kelvin = '0;
        n_status = rtc_pkg::ST_OK;
        if (r_t3[TW-1]) begin
            if ((t3_mag >> F) != '0) begin
                n_status = rtc_pkg::ST_SAT;
            end
        end else if (t3_int > MW'(65535)) begin
            n_kelvin = rtc_pkg::KELVIN_MAX;
            n_status = rtc_pkg::ST_SAT;
        end else begin
            n_kelvin = t3_int[15:0];
        end
        if (r_f5.zero) begin
            n_kelvin = '0;
            n_status = rtc_pkg::ST_ZERO;
        end else if (r_f5.sat_pos) begin
            n_kelvin = rtc_pkg::KELVIN_MAX;
            n_status = rtc_pkg::ST_SAT;
        end else if (r_f5.sat_neg) begin
            n_kelvin = '0;
            n_status = rtc_pkg::ST_SAT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1     <= n_t1;
            r_q1     <= i_q;
            r_f1     <= i_flags;
            r_p2     <= PW'(t1_mag) * PW'(r_q1);
            r_s2     <= r_t1[TW-1] ^ r_f1.neg;
            r_q2     <= r_q1;
            r_f2     <= r_f1;
            r_t2     <= n_t2;
            r_q3     <= r_q2;
            r_f3     <= r_f2;
            r_p4     <= PW'(t2_mag) * PW'(r_q3);
            r_s4     <= r_t2[TW-1] ^ r_f3.neg;
            r_q4     <= r_q3;
            r_f4     <= r_f3;
            r_t3     <= n_t3;
            r_f5     <= r_f4;
            r_kelvin <= n_kelvin;
            r_status <= n_status;
        end
    end

    assign o_valid  = r_v6;
    assign o_kelvin = r_kelvin;
    assign o_status = r_status;

endmodule

FILE: hdl/rgb_to_cct_mccamy_top.sv
// rgb_to_cct_mccamy_top: rgb sample to correlated colour temperature (mccamy)
// depends on rtc_pkg, rtc_if, rtc_div, rtc_kdiv, rtc_cubic
//
// One result transaction per sample transaction, in order; a new sample is taken
// every cycle while the result side keeps up. The pipeline stages are products,
// xyz sums, s sum, scaling multiply, two constant dividers of ceil((FRAC_BITS+33)/8)
// digit stages side by side, numerator and denominator, saturation compare,
// chromaticity divider of FRAC_BITS+3 stages and six horner stages. All stages advance
// together and hold while a finished result waits at the output register.
module rgb_to_cct_mccamy_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rtc_in_if.sink           i_pix,
    rtc_out_if.source        o_cct
);

    localparam int F  = FRAC_BITS;
    localparam int CW = F + 3;
    localparam int VW = F + 23;
    localparam int AW = VW - 1;
    localparam int QW = F + 3;
    localparam int FW = $bits(rtc_pkg::t_flags);

    function automatic logic signed [CW-1:0] fx(input longint k);
        longint m;
        m = (((k < 0) ? -k : k) <<< F) + 50000;
        m = m / 100000;
        return (k < 0) ? CW'(-m) : CW'(m);
    endfunction

    localparam logic signed [CW-1:0] COEF [9] = '{
        fx(rtc_pkg::XYZ_COEF[0]), fx(rtc_pkg::XYZ_COEF[1]), fx(rtc_pkg::XYZ_COEF[2]),
        fx(rtc_pkg::XYZ_COEF[3]), fx(rtc_pkg::XYZ_COEF[4]), fx(rtc_pkg::XYZ_COEF[5]),
        fx(rtc_pkg::XYZ_COEF[6]), fx(rtc_pkg::XYZ_COEF[7]), fx(rtc_pkg::XYZ_COEF[8])
    };

    logic                  en;
    logic signed [16:0]    ch [3];

    logic                  r_v_prod, r_v_xyz, r_v_s, r_v_m, r_v_nd, r_v_cmp;
    logic signed [VW-1:0]  r_prod [9];
    logic signed [VW-1:0]  r_x, r_y, r_z, r_s, r_x2, r_y2, r_x3, r_y3;
    logic [AW+8:0]         r_m1;
    logic [AW+10:0]        r_m2;
    logic                  r_sneg3;
    logic signed [VW-1:0]  r_num, r_den;
    logic [AW-1:0]         r_a, r_d;
    rtc_pkg::t_flags       r_flags;

    logic [AW-1:0]         s_mag;
    logic                  d1_valid, d2_valid;
    logic [AW-1:0]         q1, q2;
    logic [VW:0]           d1_side;
    logic [VW-1:0]         d2_side;
    logic signed [VW-1:0]  sc1, sc2, d1_x;
    logic                  d1_sneg;
    logic [AW-1:0]         a_mag, d_mag;
    rtc_pkg::t_flags       n_flags;
    logic                  nd_valid;
    logic [QW-1:0]         nq;
    logic [FW-1:0]         nd_side;
    logic                  c_valid;
    logic [15:0]           c_kelvin;
    logic [1:0]            c_status;

    assign en          = !c_valid || o_cct.ready;
    assign i_pix.ready = en;

    assign ch[0] = $signed({1'b0, i_pix.red});
    assign ch[1] = $signed({1'b0, i_pix.green});
    assign ch[2] = $signed({1'b0, i_pix.blue});

    assign s_mag = r_s[VW-1] ? AW'(-r_s) : AW'(r_s);

    assign d1_sneg = d1_side[VW];
    assign d1_x    = $signed(d1_side[VW-1:0]);
    assign sc1     = d1_sneg ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
    assign sc2     = d1_sneg ? -$signed({1'b0, q2}) : $signed({1'b0, q2});

    assign a_mag = r_num[VW-1] ? AW'(-r_num) : AW'(r_num);
    assign d_mag = r_den[VW-1] ? AW'(-r_den) : AW'(r_den);

    always_comb begin
        n_flags.zero    = (r_den == '0);
        n_flags.neg     = r_num[VW-1] ^ r_den[VW-1];
        n_flags.sat_pos = !n_flags.neg &&
                          ((AW+2)'(a_mag) >= (AW+2)'(d_mag) * (AW+2)'(3));
        n_flags.sat_neg = n_flags.neg && ((AW+3)'(a_mag) >= {d_mag, 3'b000});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_prod <= 1'b0;
            r_v_xyz  <= 1'b0;
            r_v_s    <= 1'b0;
            r_v_m    <= 1'b0;
            r_v_nd   <= 1'b0;
            r_v_cmp  <= 1'b0;
        end else if (en) begin
            r_v_prod <= i_pix.valid;
            r_v_xyz  <= r_v_prod;
            r_v_s    <= r_v_xyz;
            r_v_m    <= r_v_s;
            r_v_nd   <= d1_valid;
            r_v_cmp  <= r_v_nd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                r_prod[k] <= VW'(COEF[k] * ch[k % 3]);
            end
            r_x     <= r_prod[0] + r_prod[1] + r_prod[2];
            r_y     <= r_prod[3] + r_prod[4] + r_prod[5];
            r_z     <= r_prod[6] + r_prod[7] + r_prod[8];
            r_s     <= r_x + r_y + r_z;
            r_x2    <= r_x;
            r_y2    <= r_y;
            r_m1    <= (AW+9)'(s_mag) * (AW+9)'(332) + (AW+9)'(500);
            r_m2    <= (AW+11)'(s_mag) * (AW+11)'(1858) + (AW+11)'(5000);
            r_sneg3 <= r_s[VW-1];
            r_x3    <= r_x2;
            r_y3    <= r_y2;
            r_num   <= d1_x - sc1;
            r_den   <= sc2 - $signed(d2_side);
            r_a     <= a_mag;
            r_d     <= d_mag;
            r_flags <= n_flags;
        end
    end

    // 0.332 * s, rounded
    rtc_kdiv #(.NW(AW + 11), .QW(AW), .DEN(1000), .SW(VW + 1)) u_div_k1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v_m),
        .i_num   ((AW+11)'(r_m1)),
        .i_side  ({r_sneg3, r_x3}),
        .o_valid (d1_valid),
        .o_quo   (q1),
        .o_side  (d1_side)
    );

    // 0.1858 * s, rounded
    rtc_kdiv #(.NW(AW + 11), .QW(AW), .DEN(10000), .SW(VW)) u_div_k2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v_m),
        .i_num   (r_m2),
        .i_side  (r_y3),
        .o_valid (d2_valid),
        .o_quo   (q2),
        .o_side  (d2_side)
    );

    // chromaticity term n, below 8 in magnitude once saturation is split off
    rtc_div #(.QW(QW), .DW(AW), .SW(FW)) u_div_n (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v_cmp),
        .i_rem   (AW'(r_a >> 3)),
        .i_low   ({r_a[2:0], {F{1'b0}}}),
        .i_den   (r_d),
        .i_side  (FW'(r_flags)),
        .o_valid (nd_valid),
        .o_quo   (nq),
        .o_side  (nd_side)
    );

    rtc_cubic #(.F(F)) u_cubic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (nd_valid),
        .i_q      (nq),
        .i_flags  (rtc_pkg::t_flags'(nd_side)),
        .o_valid  (c_valid),
        .o_kelvin (c_kelvin),
        .o_status (c_status)
    );

    assign o_cct.valid  = c_valid;
    assign o_cct.kelvin = c_kelvin;
    assign o_cct.status = c_status;

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d1_valid == d2_valid)
        else $error("constant dividers out of step");

    a_zero_kelvin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_valid && c_status == rtc_pkg::ST_ZERO |-> c_kelvin == '0)
        else $error("zero divisor with non-zero kelvin");

    a_sat_kelvin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_valid && c_status == rtc_pkg::ST_SAT |->
        c_kelvin == '0 || c_kelvin == rtc_pkg::KELVIN_MAX)
        else $error("saturated result not at a limit");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_v_cmp) && $stable(r_a))
        else $error("pipeline moved during stall");

endmodule

FILE: sim/rgb_to_cct_mccamy_chk.sv
// rgb_to_cct_mccamy_chk: watches the sample and result channels, predicts kelvin and status
// depends on rtc_pkg and rtc_if
module rgb_to_cct_mccamy_chk #(
    parameter int FRAC_BITS = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rtc_in_if      pix,
    rtc_out_if     cct,
    output int     o_fail_cnt,
    output int     o_pending,
    output int     o_samples,
    output int     o_results
);

    typedef struct packed {
        logic [15:0] kelvin;
        logic [1:0]  status;
    } t_cct;

    t_cct cct_q[$];

    function automatic longint fx_const(longint k, longint den);
        longint m;
        m = ((k < 0 ? -k : k) <<< FRAC_BITS) + den / 2;
        m = m / den;
        return k < 0 ? -m : m;
    endfunction

    function automatic longint scaled(longint v, longint mul, longint den);
        longint m;
        m = ((v < 0 ? -v : v) * mul + den / 2) / den;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        logic [63:0] p;
        p = (64'(a < 0 ? -a : a) * 64'(b < 0 ? -b : b)) >> FRAC_BITS;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic t_cct mccamy(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        longint ch[3];
        longint xyz[3];
        longint s, numer, denom, n, t;
        logic [63:0] q;
        logic neg;
        ch[0] = r;
        ch[1] = g;
        ch[2] = b;
        for (int i = 0; i < 3; i++) begin
            xyz[i] = 0;
            for (int j = 0; j < 3; j++)
                xyz[i] += fx_const(rtc_pkg::XYZ_COEF[i*3+j], 100000) * ch[j];
        end
        s = xyz[0] + xyz[1] + xyz[2];
        numer = xyz[0] - scaled(s, 332, 1000);
        denom = scaled(s, 1858, 10000) - xyz[1];
        if (denom == 0) return '{16'd0, rtc_pkg::ST_ZERO};
        q = (64'(numer < 0 ? -numer : numer) << FRAC_BITS) /
            64'(denom < 0 ? -denom : denom);
        neg = (numer < 0) != (denom < 0);
        if (!neg && q >= (64'd3 << FRAC_BITS)) return '{rtc_pkg::KELVIN_MAX, rtc_pkg::ST_SAT};
        if (neg && q >= (64'd8 << FRAC_BITS)) return '{16'd0, rtc_pkg::ST_SAT};
        n = neg ? -longint'(q) : longint'(q);
        t = longint'(449) <<< FRAC_BITS;
        t = fx_mul(t, n) + (longint'(3525) <<< FRAC_BITS);
        t = fx_mul(t, n) + fx_const(68233, 10);
        t = fx_mul(t, n) + fx_const(552033, 100);
        if (t < 0) begin
            if (((-t) >>> FRAC_BITS) >= 1) return '{16'd0, rtc_pkg::ST_SAT};
            return '{16'd0, rtc_pkg::ST_OK};
        end
        if ((t >>> FRAC_BITS) > 65535) return '{rtc_pkg::KELVIN_MAX, rtc_pkg::ST_SAT};
        return '{16'(t >>> FRAC_BITS), rtc_pkg::ST_OK};
    endfunction

    always @(posedge i_clk) begin
        t_cct want;
        if (!i_rst_n) begin
            o_fail_cnt <= 0;
            o_pending  <= 0;
            o_samples  <= 0;
            o_results  <= 0;
        end else begin
            if (pix.valid && pix.ready) begin
                cct_q.push_back(mccamy(pix.red, pix.green, pix.blue));
                o_samples <= o_samples + 1;
            end
            if (cct.valid && cct.ready) begin
                o_results <= o_results + 1;
                if (cct_q.size() == 0) begin
                    $error("unexpected result transaction kelvin=%0d status=%0d",
                           cct.kelvin, cct.status);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    want = cct_q.pop_front();
                    if (cct.kelvin !== want.kelvin || cct.status !== want.status) begin
                        if (cct.kelvin !== want.kelvin)
                            $error("kelvin: expected %0d, got %0d", want.kelvin, cct.kelvin);
                        if (cct.status !== want.status)
                            $error("status: expected %0d, got %0d", want.status, cct.status);
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                end
            end
            o_pending <= cct_q.size();
        end
    end
endmodule

FILE: sim/tb_rgb_to_cct_mccamy_top.sv
// tb_rgb_to_cct_mccamy_top: directed and random rgb samples under varied back-pressure
// depends on rtc_pkg, rtc_if, rgb_to_cct_mccamy_top and rgb_to_cct_mccamy_chk
module tb_rgb_to_cct_mccamy_top;
    localparam int FRAC_BITS = 16;
    localparam int LATENCY   = FRAC_BITS + 15 + (FRAC_BITS + 40) / 8;
    localparam int WD_LIMIT  = 20000;

    logic i_clk;
    logic i_rst_n;
    int   fail_cnt, pending, samples, results;
    int   send_idle, recv_stall;
    int   quiet;

    rtc_in_if  pix();
    rtc_out_if cct();

    rgb_to_cct_mccamy_top #(.FRAC_BITS(FRAC_BITS)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pix(pix), .o_cct(cct)
    );

    rgb_to_cct_mccamy_chk #(.FRAC_BITS(FRAC_BITS)) u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .pix(pix), .cct(cct),
        .o_fail_cnt(fail_cnt), .o_pending(pending),
        .o_samples(samples), .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        cct.ready <= ($urandom_range(99) >= recv_stall);
    end

    // watchdog on accepted transactions
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix.valid && pix.ready) || (cct.valid && cct.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WD_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_rgb(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        while ($urandom_range(99) < send_idle) begin
            pix.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.red   <= r;
        pix.green <= g;
        pix.blue  <= b;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random(int count);
        logic [15:0] r, g, b;
        int base;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(3))
                0: begin
                    r = 16'($urandom); g = 16'($urandom); b = 16'($urandom);
                end
                1: begin
                    // near-grey samples keep n in the cubic's useful range
                    base = int'($urandom_range(65535));
                    r = 16'(base); g = 16'(base + $urandom_range(2000) - 1000);
                    b = 16'(base + $urandom_range(4000) - 2000);
                end
                2: begin
                    r = 16'($urandom_range(255));
                    g = 16'($urandom_range(255));
                    b = 16'($urandom_range(255));
                end
                default: begin
                    r = 16'($urandom_range(65535, 32768));
                    g = 16'($urandom_range(65535, 20000));
                    b = 16'($urandom_range(65535));
                end
            endcase
            send_rgb(r, g, b);
        end
    endtask

    initial begin
        pix.valid = 1'b0;
        pix.red = '0; pix.green = '0; pix.blue = '0;
        cct.ready = 1'b0;
        send_idle = 0; recv_stall = 0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // corners: zero divisor, saturation both ways, pure channels, greys
        send_rgb(16'd0, 16'd0, 16'd0);
        send_rgb(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_rgb(16'hFFFF, 16'd0, 16'd0);
        send_rgb(16'd0, 16'hFFFF, 16'd0);
        send_rgb(16'd0, 16'd0, 16'hFFFF);
        send_rgb(16'hFFFF, 16'hFFFF, 16'd0);
        send_rgb(16'hFFFF, 16'd0, 16'hFFFF);
        send_rgb(16'd0, 16'hFFFF, 16'hFFFF);
        send_rgb(16'd1, 16'd0, 16'd0);
        send_rgb(16'd0, 16'd1, 16'd0);
        send_rgb(16'd0, 16'd0, 16'd1);
        send_rgb(16'd1, 16'd1, 16'd1);
        send_rgb(16'd1000, 16'd1000, 16'd1000);
        send_rgb(16'd1200, 16'd1000, 16'd700);
        send_rgb(16'd700, 16'd1000, 16'd1300);
        send_rgb(16'd40000, 16'd30000, 16'd20000);
        send_rgb(16'd20000, 16'd30000, 16'd40000);
        send_rgb(16'hAAAA, 16'h5555, 16'hAAAA);
        send_rgb(16'h5555, 16'hAAAA, 16'h5555);
        send_rgb(16'd5000, 16'd65535, 16'd100);

        send_random(200);
        send_idle = 76; send_random(200);
        send_idle = 0; recv_stall = 76; send_random(200);
        send_idle = 28; recv_stall = 28; send_random(200);
        pix.valid <= 1'b0;
        recv_stall = 0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("sent %0d samples (corners plus random under four idling mixes), %0d results",
                 samples, results);
        if (fail_cnt == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
